// File: hdl/stack_machine_execute_macros.svh
// assertion macros for the stack machine checker
`ifndef STACK_MACHINE_EXECUTE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define SME_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// implication checked in the following cycle
`define SME_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: hdl/sme_pkg.sv
package sme_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int IMM_BITS    = 24;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSHC = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_RDINT = 8'd7;
    localparam logic [7:0] OP_WRINT = 8'd8;
    localparam logic [7:0] OP_RDCHR = 8'd9;
    localparam logic [7:0] OP_WRCHR = 8'd10;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_UNDER = 2'd2;
    localparam logic [1:0] ERR_OVER  = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_CHR  = 2'd2;

    typedef enum logic [3:0] {
        C_NOP, C_HALT, C_PUSH, C_ADD, C_SUB, C_MUL, C_DIV, C_MOD, C_WRINT, C_WRCHR
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] value;
    } uop_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIVW, S_DIV, S_WB, S_OUT
    } state_t;

endpackage

// File: hdl/stack_machine_execute.sv
// stack machine executor: one instruction item in, one result item out. a front
// stage decodes into a two-entry queue; the back end runs each instruction against
// a 128-word operand stack held in a single-port memory. push, halt and stopped
// items go straight out; write-int/char read the top word; arithmetic reads both
// operands, div/mod via the bit-serial divider. after halt or an error every item
// returns halted with its latched error code; stack is undefined until pushed.
module stack_machine_execute (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   opcode,
    input  logic signed [23:0] immediate,
    input  logic signed [31:0] read_value,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   write_kind,
    output logic signed [31:0] write_value,
    output logic         halted,
    output logic [1:0]   error_code
);
    import sme_pkg::*;

    logic q_valid, q_ready;
    uop_t q_data;

    sme_front u_front (
        .clk (clk), .rst_n (rst_n),
        .in_valid (in_valid), .in_ready (in_ready),
        .opcode (opcode), .immediate (immediate), .read_value (read_value),
        .q_valid (q_valid), .q_ready (q_ready), .q_data (q_data)
    );

    sme_back u_back (
        .clk (clk), .rst_n (rst_n),
        .q_valid (q_valid), .q_ready (q_ready), .q_data (q_data),
        .out_valid (out_valid), .out_ready (out_ready),
        .write_kind (write_kind), .write_value (write_value),
        .halted (halted), .error_code (error_code)
    );
endmodule

// File: hdl/sme_front.sv
module sme_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   opcode,
    input  logic signed [23:0] immediate,
    input  logic signed [31:0] read_value,
    output logic         q_valid,
    input  logic         q_ready,
    output sme_pkg::uop_t q_data
);
    import sme_pkg::*;

    // two-entry queue
    uop_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    uop_t       u;
    logic       push, pop;

    always_comb
    begin
        u.value = 32'd0;
        unique case (opcode) inside
            OP_HALT:  u.cls = C_HALT;
            OP_PUSHC:
            begin
                u.cls   = C_PUSH;
                u.value = {{(32 - IMM_BITS){immediate[IMM_BITS-1]}}, immediate};
            end
            OP_RDINT, OP_RDCHR:
            begin
                u.cls   = C_PUSH;
                u.value = read_value;
            end
            OP_ADD:   u.cls = C_ADD;
            OP_SUB:   u.cls = C_SUB;
            OP_MUL:   u.cls = C_MUL;
            OP_DIV:   u.cls = C_DIV;
            OP_MOD:   u.cls = C_MOD;
            OP_WRINT: u.cls = C_WRINT;
            OP_WRCHR: u.cls = C_WRCHR;
            default:  u.cls = C_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: hdl/sme_divider.sv
module sme_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    // unsigned restoring divider, one bit a cycle
    logic [31:0] q_reg, r_reg, d_reg;
    logic [5:0]  n_reg;
    logic        busy_reg;
    logic [32:0] trial;

    assign trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
    assign done      = busy_reg && (n_reg == 6'd0);
    assign quotient  = q_reg;
    assign remainder = r_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 32'd0;
            d_reg <= divisor;
        end
        else if (busy_reg && n_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 6'd32;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg - 6'd1;
        end
    end
endmodule

// File: hdl/sme_back.sv
module sme_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  sme_pkg::uop_t q_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   write_kind,
    output logic signed [31:0] write_value,
    output logic         halted,
    output logic [1:0]   error_code
);
    import sme_pkg::*;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic        rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    state_t state_reg, state_next;
    uop_t   uop_reg, uop_next;
    logic [PTR_W-1:0] sp_reg, sp_next;
    logic   stop_reg, stop_next;
    logic [1:0] err_reg, err_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, r_reg, r_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] wval_reg, wval_next;
    logic        neg_reg, neg_next;
    logic [63:0] prod;

    logic        dv_start, dv_done;
    logic [31:0] dv_q, dv_r, mag_a, mag_b;

    assign mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign prod  = a_reg * b_reg;

    sme_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en) stack_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            stop_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uop_reg  <= uop_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        kind_reg <= kind_next;
        wval_reg <= wval_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        sp_next    = sp_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        kind_next  = kind_reg;
        wval_next  = wval_reg;
        neg_next   = neg_reg;
        q_ready    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_reg;
        dv_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    uop_next  = q_data;
                    kind_next = KIND_NONE;
                    wval_next = 32'd0;
                    state_next = S_OUT;
                    if (!stop_reg)
                    begin
                        unique case (q_data.cls) inside
                            C_HALT:
                            begin
                                stop_next = 1'b1;
                                err_next  = ERR_NONE;
                            end
                            C_PUSH:
                            begin
                                if (sp_reg == PTR_W'(STACK_DEPTH))
                                begin
                                    stop_next = 1'b1;
                                    err_next  = ERR_OVER;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = sp_reg[ADDR_W-1:0];
                                    wr_data = q_data.value;
                                    sp_next = sp_reg + PTR_W'(1);
                                end
                            end
                            C_WRINT, C_WRCHR:
                            begin
                                if (sp_reg == '0)
                                begin
                                    stop_next = 1'b1;
                                    err_next  = ERR_UNDER;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = ADDR_W'(sp_reg - PTR_W'(1));
                                    state_next = S_RD1;
                                end
                            end
                            C_ADD, C_SUB, C_MUL, C_DIV, C_MOD:
                            begin
                                if (sp_reg < PTR_W'(2))
                                begin
                                    stop_next = 1'b1;
                                    err_next  = ERR_UNDER;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = ADDR_W'(sp_reg - PTR_W'(1));
                                    state_next = S_RD1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_RD1:
            begin
                if (uop_reg.cls == C_WRINT || uop_reg.cls == C_WRCHR)
                begin
                    sp_next = sp_reg - PTR_W'(1);
                    if (uop_reg.cls == C_WRINT)
                    begin
                        kind_next = KIND_INT;
                        wval_next = rd_data_reg;
                    end
                    else
                    begin
                        kind_next = KIND_CHR;
                        wval_next = {24'd0, rd_data_reg[7:0]};
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    b_next     = rd_data_reg;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(sp_reg - PTR_W'(2));
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                a_next     = rd_data_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (uop_reg.cls)
                    C_ADD:
                    begin
                        r_next     = a_reg + b_reg;
                        state_next = S_WB;
                    end
                    C_SUB:
                    begin
                        r_next     = a_reg - b_reg;
                        state_next = S_WB;
                    end
                    C_MUL:
                    begin
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            stop_next  = 1'b1;
                            err_next   = ERR_DIV0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            dv_start   = 1'b1;
                            neg_next   = (uop_reg.cls == C_DIV) ? (a_reg[31] ^ b_reg[31])
                                                                : a_reg[31];
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                r_next     = prod[31:0];
                state_next = S_WB;
            end
            S_DIV:
            begin
                if (dv_done)
                begin
                    r_next = (uop_reg.cls == C_DIV) ? dv_q : dv_r;
                    if (neg_reg)
                    begin
                        r_next = 32'd0 - ((uop_reg.cls == C_DIV) ? dv_q : dv_r);
                    end
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(sp_reg - PTR_W'(2));
                sp_next    = sp_reg - PTR_W'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid   = (state_reg == S_OUT);
    assign write_kind  = kind_reg;
    assign write_value = wval_reg;
    assign halted      = stop_reg;
    assign error_code  = stop_reg ? err_reg : ERR_NONE;
endmodule

// File: hdl/sme_checker.sv
`include "stack_machine_execute_macros.svh"

module sme_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  write_kind,
    input logic        halted,
    input logic [1:0]  error_code
);
    import sme_pkg::*;

    // once stopped, stays stopped
    `SME_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted, halted)
    // error only reported while halted
    `SME_ASSERT_IMP(a_err_halted, clk, rst_n, error_code != ERR_NONE, halted)
    // a stopped machine writes nothing
    `SME_ASSERT_IMP(a_no_write_halted, clk, rst_n, out_valid && halted, write_kind == KIND_NONE)
    // kind is never the unused code
    `SME_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid, (write_kind == KIND_NONE || write_kind == KIND_INT || write_kind == KIND_CHR))
    // a result item waits until taken
    `SME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind stack_machine_execute sme_checker u_checker (
    .clk (clk), .rst_n (rst_n), .out_valid (out_valid), .out_ready (out_ready),
    .write_kind (write_kind), .halted (halted), .error_code (error_code)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sme_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] opcode;
    logic signed [23:0] immediate;
    logic signed [31:0] read_value;
    logic out_valid;
    logic out_ready;
    logic [1:0] write_kind;
    logic signed [31:0] write_value;
    logic halted;
    logic [1:0] error_code;

    stack_machine_execute dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .immediate(immediate), .read_value(read_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .write_kind(write_kind), .write_value(write_value),
        .halted(halted), .error_code(error_code)
    );

    typedef struct packed {
        logic [7:0]  op;
        logic [23:0] imm;
        logic [31:0] rd;
    } instr_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        stop;
        logic [1:0]  err;
    } outcome_t;

    instr_t   instr_q[$];
    outcome_t outcome_q[$];

    // predictor copy of the machine
    logic [31:0] stk[STACK_DEPTH];
    int          sp;
    logic        is_stopped;
    logic [1:0]  err_latched;

    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    bit hold_req;
    int hold_cnt;
    bit in_taken;
    int cycle_count;
    int model_depth;

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    task automatic execute_instr(instr_t it);
        outcome_t o;
        logic [31:0] a, b, r;
        o = '0;
        if (!is_stopped) begin
            case (it.op) inside
                OP_HALT:
                begin
                    is_stopped = 1; err_latched = ERR_NONE;
                end
                OP_PUSHC, OP_RDINT, OP_RDCHR:
                begin
                    if (sp >= STACK_DEPTH)
                    begin
                        is_stopped = 1; err_latched = ERR_OVER;
                    end
                    else
                    begin
                        stk[sp] = (it.op == OP_PUSHC) ? {{8{it.imm[23]}}, it.imm} : it.rd;
                        sp++;
                    end
                end
                OP_WRINT, OP_WRCHR:
                begin
                    if (sp < 1)
                    begin
                        is_stopped = 1; err_latched = ERR_UNDER;
                    end
                    else
                    begin
                        sp--;
                        o.kind = (it.op == OP_WRINT) ? KIND_INT : KIND_CHR;
                        o.value = (it.op == OP_WRINT) ? stk[sp] : {24'd0, stk[sp][7:0]};
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                begin
                    if (sp < 2)
                    begin
                        is_stopped = 1; err_latched = ERR_UNDER;
                    end
                    else
                    begin
                        a = stk[sp-2]; b = stk[sp-1];
                        if ((it.op == OP_DIV || it.op == OP_MOD) && b == 0)
                        begin
                            is_stopped = 1; err_latched = ERR_DIV0;
                        end
                        else
                        begin
                            case (it.op)
                                OP_ADD: r = a + b;
                                OP_SUB: r = a - b;
                                OP_MUL: r = a * b;
                                OP_DIV:
                                begin
                                    r = mag(a) / mag(b);
                                    if (a[31] != b[31]) r = 32'd0 - r;
                                end
                                default:
                                begin
                                    r = mag(a) % mag(b);
                                    if (a[31]) r = 32'd0 - r;
                                end
                            endcase
                            sp--;
                            stk[sp-1] = r;
                        end
                    end
                end
                default: ;
            endcase
        end
        o.stop = is_stopped;
        o.err = is_stopped ? err_latched : ERR_NONE;
        outcome_q.push_back(o);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // input handshake as seen at the rising edge
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_CYCLES) hold_cnt++;
        hold_off = hold_req && (hold_cnt < HOLD_CYCLES);
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0; opcode <= 0; immediate <= 0; read_value <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                instr_t it;
                it = instr_q.pop_front();
                execute_instr(it);
                in_valid <= 1; opcode <= it.op; immediate <= it.imm; read_value <= it.rd;
            end
            else
                in_valid <= 0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    outcome_t w;
                    w = outcome_q.pop_front();
                    if (write_kind !== w.kind)
                        report("write_kind", 32'(write_kind), 32'(w.kind));
                    if (write_value !== w.value) report("write_value", write_value, w.value);
                    if (halted !== w.stop) report("halted", 32'(halted), 32'(w.stop));
                    if (error_code !== w.err)
                        report("error_code", 32'(error_code), 32'(w.err));
                end
            end
            if (cycle_count > 400000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // one item after a handshake: driver pops and predicts at the same falling edge
    function automatic instr_t mk(logic [7:0] op, logic [23:0] imm, logic [31:0] rd);
        instr_t it;
        it.op = op; it.imm = imm; it.rd = rd;
        return it;
    endfunction

    task automatic drain();
        while (instr_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_program(int n);
        int k;
        logic [7:0] op;
        for (k = 0; k < n; k++)
        begin
            if (model_depth < 2 || $urandom_range(2) == 0)
                op = ($urandom_range(1)) ? OP_PUSHC : (($urandom_range(1)) ? OP_RDINT : OP_RDCHR);
            else
            begin
                case ($urandom_range(6))
                    0: op = OP_ADD;
                    1: op = OP_SUB;
                    2: op = OP_MUL;
                    3: op = OP_DIV;
                    4: op = OP_MOD;
                    5: op = OP_WRINT;
                    default: op = OP_WRCHR;
                endcase
            end
            if ($urandom_range(15) == 0)
                op = 8'(11 + $urandom_range(244));
            if (model_depth >= STACK_DEPTH - 1 && (op == OP_PUSHC || op == OP_RDINT ||
                op == OP_RDCHR))
                op = OP_WRINT;
            case (op) inside
                OP_PUSHC, OP_RDINT, OP_RDCHR: model_depth++;
                OP_ADD, OP_SUB, OP_MUL, OP_WRINT, OP_WRCHR: model_depth--;
                OP_DIV, OP_MOD: model_depth--;
                default: ;
            endcase
            // avoid zero divisors in random part: push nonzero before div/mod
            if (op == OP_DIV || op == OP_MOD)
            begin
                instr_q.push_back(mk(OP_PUSHC, 24'(($urandom_range(1) ? 24'h800000 : 24'd0) |
                    24'd1 | $urandom), 0));
                instr_q.push_back(mk(op, 24'($urandom), $urandom));
                model_depth += 1;
            end
            else
                instr_q.push_back(mk(op, 24'($urandom), $urandom));
        end
    endtask

    initial
    begin
        errors = 0; cycle_count = 0; hold_req = 0; hold_cnt = 0; model_depth = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        sp = 0; is_stopped = 0; err_latched = ERR_NONE;
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, every operation but halt, min / -1
        instr_q.push_back(mk(OP_PUSHC, 24'h7fffff, 0));
        instr_q.push_back(mk(OP_PUSHC, 24'h800000, 0));
        instr_q.push_back(mk(OP_ADD, 0, 0));
        instr_q.push_back(mk(OP_WRINT, 0, 0));
        instr_q.push_back(mk(OP_RDINT, 24'hffffff, 32'h80000000));
        instr_q.push_back(mk(OP_RDINT, 0, 32'hffffffff));
        instr_q.push_back(mk(OP_DIV, 0, 0));
        instr_q.push_back(mk(OP_RDINT, 0, 32'h80000000));
        instr_q.push_back(mk(OP_RDINT, 0, 32'hffffffff));
        instr_q.push_back(mk(OP_MOD, 0, 0));
        instr_q.push_back(mk(OP_SUB, 0, 0));
        instr_q.push_back(mk(OP_RDCHR, 0, 32'h7fffffff));
        instr_q.push_back(mk(OP_RDINT, 0, -32'sd7));
        instr_q.push_back(mk(OP_MUL, 0, 0));
        instr_q.push_back(mk(OP_WRCHR, 0, 0));
        instr_q.push_back(mk(8'hff, 24'h123456, 32'hdeadbeef));
        instr_q.push_back(mk(OP_RDINT, 0, -32'sd7));
        instr_q.push_back(mk(OP_PUSHC, 24'd2, 0));
        instr_q.push_back(mk(OP_MOD, 0, 0));
        instr_q.push_back(mk(OP_WRINT, 0, 0));
        instr_q.push_back(mk(OP_WRINT, 0, 0));
        model_depth = 0;
        drain();

        // random phases with different idling, then long hold-off
        send_idle_pct = 0;  recv_stall_pct = 0;  random_program(80); drain();
        send_idle_pct = 47; recv_stall_pct = 0;  random_program(80); drain();
        send_idle_pct = 0;  recv_stall_pct = 47; random_program(80); drain();
        send_idle_pct = 17; recv_stall_pct = 17;
        hold_req = 1;
        random_program(80);
        drain();

        // push to overflow, then check stopped behaviour
        send_idle_pct = 0; recv_stall_pct = 0;
        while (model_depth < STACK_DEPTH)
        begin
            instr_q.push_back(mk(OP_PUSHC, 24'($urandom), 0));
            model_depth++;
        end
        instr_q.push_back(mk(OP_RDINT, 0, $urandom));
        instr_q.push_back(mk(OP_WRINT, 0, 0));
        instr_q.push_back(mk(OP_HALT, 0, 0));
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
